// ===== hdl/ftl_pkg.sv =====
// ----------------------------------------------------------------------------
// ftl_pkg - shared types and constants of the formula token lexer
// Token kinds, lexer modes, character codes, the result record and the
// expected token-kind pattern of a well-formed range formula.
// ----------------------------------------------------------------------------
package ftl_pkg;

    // Default width of the byte position counter
    localparam int POSITION_BITS_DEF = 8;

    // Entries of the result queue
    localparam int QUEUE_DEPTH = 4;

    // Token kinds as carried on the result channel
    typedef enum logic [2:0] {
        KIND_CELL  = 3'd0,
        KIND_FUNC  = 3'd1,
        KIND_SYM   = 3'd2,
        KIND_RANGE = 3'd3,
        KIND_END   = 3'd4,
        KIND_ERR   = 3'd5
    } token_kind_t;

    // Lexer modes, one-hot
    typedef enum logic [3:0] {
        MODE_IDLE  = 4'b0001,
        MODE_IDENT = 4'b0010,
        MODE_DOTS  = 4'b0100,
        MODE_SKIP  = 4'b1000
    } lex_mode_t;

    // Character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_UNDER = 8'h5F;

    // Dots in a range separator
    localparam logic [2:0] RANGE_DOTS = 3'd3;

    // Tokens that take part in the pattern check
    localparam logic [2:0] PATTERN_LEN = 3'd6;
    // Tokens needed before the final end for the formula to count as valid
    localparam logic [2:0] PATTERN_MIN = 3'd5;

    // One result item
    typedef struct packed {
        token_kind_t kind;
        logic [7:0]  chr;
        logic [7:0]  start;
        logic [7:0]  length;
        logic        valid;
        logic        last;
    } result_t;

    // Results produced by one input byte, handed to the queue
    typedef struct packed {
        logic [1:0] cnt;
        result_t    res0;
        result_t    res1;
    } push_t;

    // Expected kind of the token at each place of the pattern
    function automatic token_kind_t want_kind(input logic [2:0] idx);
        token_kind_t k;
        case (idx)
            3'd0:    k = KIND_FUNC;
            3'd1:    k = KIND_SYM;
            3'd2:    k = KIND_CELL;
            3'd3:    k = KIND_RANGE;
            3'd4:    k = KIND_CELL;
            3'd5:    k = KIND_END;
            default: k = KIND_ERR;
        endcase
        return k;
    endfunction

    // Advance the pattern check by one token: returns {index, ok}
    function automatic logic [3:0] note_token(input logic [2:0] idx, input logic ok,
                                              input token_kind_t k);
        logic [2:0] idx_n;
        logic       ok_n;
        idx_n = idx;
        ok_n  = ok;
        if (idx < PATTERN_LEN) begin
            if (want_kind(idx) != k) begin
                ok_n = 1'b0;
            end
            idx_n = idx + 3'd1;
        end
        return {idx_n, ok_n};
    endfunction

endpackage

// ===== hdl/ftl_lex_core.sv =====
// ----------------------------------------------------------------------------
// ftl_lex_core - lexer state and per-byte token decision
// Holds the lexer mode and the identifier / dot-run trackers, and turns one
// registered byte combinationally into up to two result items.
// ----------------------------------------------------------------------------
module ftl_lex_core #(
    parameter int POSITION_BITS = ftl_pkg::POSITION_BITS_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           step,
    input  logic [7:0]     char_code,
    output ftl_pkg::push_t push
);
    import ftl_pkg::*;

    localparam int EXT_W = (POSITION_BITS > 8) ? POSITION_BITS : 8;
    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

    lex_mode_t              mode_reg,   mode_next;
    logic [7:0]             len_reg,    len_next;
    logic [7:0]             start_reg,  start_next;
    logic                   digit_reg,  digit_next;
    logic [2:0]             dots_reg,   dots_next;
    logic [POSITION_BITS-1:0] pos_reg,  pos_next;
    logic [2:0]             tidx_reg,   tidx_next;
    logic                   pok_reg,    pok_next;

    logic [EXT_W-1:0] pos_wide;
    logic [7:0]       cur_pos;
    logic             is_alpha, is_digit, is_sym;
    logic             a_emit, b_emit, do_idle, fin;
    result_t          a_res, b_res;

    // Classify the byte
    assign is_alpha = (char_code inside {[8'h41:8'h5A], [8'h61:8'h7A]});
    assign is_digit = (char_code inside {[8'h30:8'h39]});
    assign is_sym   = (char_code == CH_PLUS) || (char_code == CH_MINUS) ||
                      (char_code == CH_STAR) || (char_code == CH_SLASH) ||
                      (char_code == CH_LPAR);

    // Position of this byte, saturated to the token field
    assign pos_wide = EXT_W'(pos_reg);
    assign cur_pos  = (pos_wide > EXT_W'(255)) ? 8'hFF : pos_wide[7:0];

    // Next state and results for the byte
    always_comb begin
        mode_next  = mode_reg;
        len_next   = len_reg;
        start_next = start_reg;
        digit_next = digit_reg;
        dots_next  = dots_reg;
        pos_next   = (pos_reg != POS_MAX) ? pos_reg + POSITION_BITS'(1) : pos_reg;
        tidx_next  = tidx_reg;
        pok_next   = pok_reg;
        a_emit     = 1'b0;
        a_res      = '0;
        b_emit     = 1'b0;
        b_res      = '0;
        do_idle    = 1'b0;
        fin        = 1'b0;

        // First stage: finish or extend a pending identifier or dot run
        case (mode_reg)
            MODE_IDENT: begin
                if (is_alpha || is_digit || char_code == CH_UNDER) begin
                    if (len_reg != 8'hFF) begin
                        len_next = len_reg + 8'd1;
                    end
                    if (is_digit) begin
                        digit_next = 1'b1;
                    end
                end else begin
                    a_emit       = 1'b1;
                    a_res.kind   = digit_reg ? KIND_CELL : KIND_FUNC;
                    a_res.start  = start_reg;
                    a_res.length = len_reg;
                    {tidx_next, pok_next} = note_token(tidx_next, pok_next, a_res.kind);
                    do_idle = 1'b1;
                end
            end
            MODE_DOTS: begin
                if (char_code == CH_DOT) begin
                    if (dots_reg != 3'd7) begin
                        dots_next = dots_reg + 3'd1;
                    end
                end else if (dots_reg == RANGE_DOTS) begin
                    a_emit       = 1'b1;
                    a_res.kind   = KIND_RANGE;
                    a_res.start  = start_reg;
                    a_res.length = {5'd0, RANGE_DOTS};
                    {tidx_next, pok_next} = note_token(tidx_next, pok_next, KIND_RANGE);
                    do_idle = 1'b1;
                end else begin
                    a_emit       = 1'b1;
                    a_res.kind   = KIND_ERR;
                    a_res.start  = start_reg;
                    a_res.length = {5'd0, dots_reg};
                    pok_next     = 1'b0;
                    mode_next    = MODE_SKIP;
                    fin          = (char_code == CH_NUL);
                end
            end
            MODE_SKIP: begin
                fin = (char_code == CH_NUL);
            end
            default: begin
                do_idle = 1'b1;
            end
        endcase

        // Second stage: lex the byte from the idle mode
        if (do_idle) begin
            mode_next = MODE_IDLE;
            if (char_code == CH_NUL) begin
                fin = 1'b1;
            end else if (is_alpha) begin
                mode_next  = MODE_IDENT;
                start_next = cur_pos;
                len_next   = 8'd1;
                digit_next = 1'b0;
            end else if (is_sym || char_code == CH_RPAR) begin
                b_emit       = 1'b1;
                b_res.kind   = is_sym ? KIND_SYM : KIND_END;
                b_res.chr    = char_code;
                b_res.start  = cur_pos;
                b_res.length = 8'd1;
                {tidx_next, pok_next} = note_token(tidx_next, pok_next, b_res.kind);
            end else if (char_code == CH_DOT) begin
                mode_next  = MODE_DOTS;
                start_next = cur_pos;
                dots_next  = 3'd1;
            end else if (char_code == CH_SPACE || char_code == CH_LF) begin
                mode_next = MODE_IDLE;
            end else begin
                b_emit       = 1'b1;
                b_res.kind   = KIND_ERR;
                b_res.start  = cur_pos;
                b_res.length = 8'd1;
                pok_next     = 1'b0;
                mode_next    = MODE_SKIP;
            end
        end

        // Formula end: final end token, then clear the per-formula state
        if (fin) begin
            b_emit       = 1'b1;
            b_res        = '0;
            b_res.kind   = KIND_END;
            b_res.start  = cur_pos;
            b_res.valid  = pok_next && (tidx_next >= PATTERN_MIN);
            mode_next    = MODE_IDLE;
            len_next     = 8'd0;
            start_next   = 8'd0;
            digit_next   = 1'b0;
            dots_next    = 3'd0;
            pos_next     = '0;
            tidx_next    = 3'd0;
            pok_next     = 1'b1;
        end
    end

    // Order the results and mark the last one
    always_comb begin
        push = '0;
        if (a_emit) begin
            push.res0 = a_res;
            push.res1 = b_res;
            push.cnt  = b_emit ? 2'd2 : 2'd1;
        end else begin
            push.res0 = b_res;
            push.cnt  = b_emit ? 2'd1 : 2'd0;
        end
        push.res0.last = (push.cnt == 2'd1);
        push.res1.last = (push.cnt == 2'd2);
        if (!step) begin
            push.cnt = 2'd0;
        end
    end

    // Lexer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_IDLE;
            len_reg   <= 8'd0;
            start_reg <= 8'd0;
            digit_reg <= 1'b0;
            dots_reg  <= 3'd0;
            pos_reg   <= '0;
            tidx_reg  <= 3'd0;
            pok_reg   <= 1'b1;
        end else if (step) begin
            mode_reg  <= mode_next;
            len_reg   <= len_next;
            start_reg <= start_next;
            digit_reg <= digit_next;
            dots_reg  <= dots_next;
            pos_reg   <= pos_next;
            tidx_reg  <= tidx_next;
            pok_reg   <= pok_next;
        end
    end

endmodule

// ===== hdl/ftl_out_queue.sv =====
// ----------------------------------------------------------------------------
// ftl_out_queue - result queue in front of the result channel
// Takes up to two results per cycle from the lexer and presents them one
// transfer at a time; reports whether the next byte's results will fit.
// ----------------------------------------------------------------------------
module ftl_out_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  ftl_pkg::push_t   push,
    output logic             room,
    output logic             m_tvalid,
    input  logic             m_tready,
    output ftl_pkg::result_t head
);
    import ftl_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    result_t          q_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             pop;

    assign m_tvalid = (count_reg != '0);
    assign pop      = m_tvalid && m_tready;
    assign head     = q_reg[head_reg];

    // Two free entries after this cycle's pop
    assign room = (count_reg <= CNT_W'(QUEUE_DEPTH - 2)) ||
                  (pop && count_reg == CNT_W'(QUEUE_DEPTH - 1));

    // Pointer and fill count update
    always_comb begin
        head_next  = pop ? head_reg + PTR_W'(1) : head_reg;
        tail_next  = tail_reg + PTR_W'(push.cnt);
        count_next = count_reg + CNT_W'(push.cnt) - CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // Store the results of one byte
    always_ff @(posedge aclk) begin
        if (push.cnt != 2'd0) begin
            q_reg[tail_reg] <= push.res0;
        end
        if (push.cnt == 2'd2) begin
            q_reg[tail_reg + PTR_W'(1)] <= push.res1;
        end
    end

    // Fill count stays within the queue
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("result queue count out of range");

    // A push never overruns the queue
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (push.cnt != 2'd0) |->
        ((count_reg - CNT_W'(pop) + CNT_W'(push.cnt)) <= CNT_W'(QUEUE_DEPTH)))
        else $error("result queue overrun");

    // The partner of a non-last result is already queued
    a_pair_queued: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !head.last) |=> m_tvalid)
        else $error("second result of a byte missing");

endmodule

// ===== hdl/formula_token_lexer.sv =====
// ----------------------------------------------------------------------------
// formula_token_lexer - streaming tokenizer for spreadsheet formulas
// Lexes formula bytes into cell, function, symbol, range, end and error
// tokens and checks the first six tokens against the range-formula pattern.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one formula byte per transfer in s_tdata[7:0]; byte 0 ends
//   the formula and yields a final end token carrying formula_valid.
//   m_ channel: one token per transfer; m_tuser holds the token kind and
//   m_tlast marks the last result caused by an input byte (a byte gives
//   zero, one or two results).
//   Path: a byte is registered in the input register on its transfer and
//   lexed once the queue has room; its results pass through the queue to m_.
//   Throughput: one byte per cycle while results are taken as they come; a
//   byte with two results needs two transfers on the result channel, and
//   the four-entry result queue absorbs it, so s_tready drops only when
//   the queue backs up.
//   Stall: with m_tready low the queue fills, lexing halts once fewer than
//   two entries are free, and s_tready falls after the input register holds
//   a byte. Nothing is dropped.
//   Reset: aresetn low clears the lexer to the idle mode at position zero,
//   empties the queue and the input register.
// ----------------------------------------------------------------------------
module formula_token_lexer #(
    parameter int POSITION_BITS = ftl_pkg::POSITION_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_code
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [7:0] token_char, [15:8] token_start,
                                   // [23:16] token_length, [24] formula_valid,
                                   // [31:25] zero
    output logic [2:0]  m_tuser,   // [2:0] token_kind
    output logic        m_tlast    // last_result
);
    import ftl_pkg::*;

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_char_reg;
    logic       room, step, s_xfer;
    push_t      push;
    result_t    head;

    // Input register: hold a byte until the queue has room for its results
    assign step     = in_valid_reg && room;
    assign s_tready = !in_valid_reg || step;
    assign s_xfer   = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_xfer) begin
            in_valid_next = 1'b1;
        end else if (step) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            in_char_reg <= s_tdata;
        end
    end

    ftl_lex_core #(
        .POSITION_BITS(POSITION_BITS)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .char_code (in_char_reg),
        .push      (push)
    );

    ftl_out_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .room     (room),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .head     (head)
    );

    // Pack the head result onto the result channel
    assign m_tdata = {7'd0, head.valid, head.length, head.start, head.chr};
    assign m_tuser = head.kind;
    assign m_tlast = head.last;

endmodule

// ===== tb/sv/tb_formula_token_lexer.sv =====
// ----------------------------------------------------------------------------
// tb_formula_token_lexer - self-checking regression of the formula lexer
// Streams formula bytes into the lexer and predicts every token in a
// behavioural model of its own. The run opens with a table of directed
// bytes, some of them with the tokens written out, and then sends random
// formulas: well-formed range formulas with random names, plus token
// mixtures, broken formulas, raw noise and two very long lines. Both
// channels idle at random.
// ----------------------------------------------------------------------------
module tb_formula_token_lexer;

    import ftl_pkg::*;

    localparam int POS_BITS        = POSITION_BITS_DEF;
    localparam int POS_MAX         = (1 << POS_BITS) - 1;
    localparam int CYCLE_LIMIT     = 500000;
    localparam int RANDOM_ITEMS    = 1200;
    localparam int QUIET_AFTER     = 1050;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES    = 20;
    localparam int SHOWN_MISSES    = 10;
    localparam int LONG_IDENT_AT   = 4;
    localparam int LONG_LINE_AT    = 9;
    localparam result_t NO_TOKEN   = '0;

    // One directed byte; typed_n > 0 means its tokens are written out here
    typedef struct {
        logic [7:0] c;
        int         typed_n;
        result_t    r0;
        result_t    r1;
    } stim_row_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;  // [7:0] char_code
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;           // [7:0] token_char, [15:8] token_start,
                                    // [23:16] token_length, [24] formula_valid
    logic [2:0]  m_tuser;           // [2:0] token_kind
    logic        m_tlast;           // last_result

    // Lexer state as predicted
    lex_mode_t   lex_state   = MODE_IDLE;
    logic [7:0]  ident_len   = 8'd0;
    int          ident_start = 0;
    logic        ident_digit = 1'b0;
    logic [2:0]  dots_seen   = 3'd0;
    int          byte_pos    = 0;
    logic [2:0]  tokens_seen = 3'd0;
    logic        shape_ok    = 1'b1;
    int          here_pos    = 0;
    token_kind_t range_shape [6] = '{KIND_FUNC, KIND_SYM, KIND_CELL,
                                     KIND_RANGE, KIND_CELL, KIND_END};

    result_t     step_tokens [$];
    result_t     token_queue [$];
    logic [7:0]  formula_text [$];
    logic [7:0]  sym_chars [5] = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_LPAR};

    int          miss_count   = 0;
    int          sent_count   = 0;
    int          cycle_count  = 0;
    logic        idling_on    = 1'b1;
    logic        hold_off_req = 1'b0;

    stim_row_t directed_rows [25] = '{
        '{8'hFF,    1, '{KIND_ERR, 8'h00, 8'd0, 8'd1, 1'b0, 1'b1}, NO_TOKEN},
        '{"a",      0, NO_TOKEN, NO_TOKEN},
        '{CH_NUL,   1, '{KIND_END, 8'h00, 8'd2, 8'd0, 1'b0, 1'b1}, NO_TOKEN},
        '{"S",      0, NO_TOKEN, NO_TOKEN},
        '{"U",      0, NO_TOKEN, NO_TOKEN},
        '{"M",      0, NO_TOKEN, NO_TOKEN},
        '{CH_LPAR,  0, NO_TOKEN, NO_TOKEN},
        '{"A",      0, NO_TOKEN, NO_TOKEN},
        '{"1",      0, NO_TOKEN, NO_TOKEN},
        '{CH_DOT,   0, NO_TOKEN, NO_TOKEN},
        '{CH_DOT,   0, NO_TOKEN, NO_TOKEN},
        '{CH_DOT,   0, NO_TOKEN, NO_TOKEN},
        '{"B",      0, NO_TOKEN, NO_TOKEN},
        '{"2",      0, NO_TOKEN, NO_TOKEN},
        '{CH_RPAR,  0, NO_TOKEN, NO_TOKEN},
        '{CH_NUL,   1, '{KIND_END, 8'h00, 8'd12, 8'd0, 1'b1, 1'b1}, NO_TOKEN},
        '{CH_SPACE, 0, NO_TOKEN, NO_TOKEN},
        '{CH_LF,    0, NO_TOKEN, NO_TOKEN},
        '{CH_PLUS,  0, NO_TOKEN, NO_TOKEN},
        '{CH_MINUS, 0, NO_TOKEN, NO_TOKEN},
        '{CH_STAR,  0, NO_TOKEN, NO_TOKEN},
        '{CH_SLASH, 0, NO_TOKEN, NO_TOKEN},
        '{CH_DOT,   0, NO_TOKEN, NO_TOKEN},
        '{CH_DOT,   0, NO_TOKEN, NO_TOKEN},
        '{CH_NUL,   2, '{KIND_ERR, 8'h00, 8'd6, 8'd2, 1'b0, 1'b0},
                       '{KIND_END, 8'h00, 8'd8, 8'd0, 1'b0, 1'b1}}
    };

    formula_token_lexer u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Clock: period 10
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Token prediction
    // ------------------------------------------------------------------
    function automatic logic is_letter(input logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic [7:0] clip8(input int v);
        return (v > 255) ? 8'hFF : 8'(v);
    endfunction

    function automatic void put_token(input token_kind_t kind, input logic [7:0] chr,
                                      input int start, input int len, input logic valid);
        result_t r;
        r.kind   = kind;
        r.chr    = chr;
        r.start  = clip8(start);
        r.length = clip8(len);
        r.valid  = valid;
        r.last   = 1'b0;
        step_tokens.push_back(r);
    endfunction

    // Token that counts towards the range-formula shape
    function automatic void put_counted(input token_kind_t kind, input logic [7:0] chr,
                                        input int start, input int len);
        if (tokens_seen < PATTERN_LEN) begin
            if (range_shape[tokens_seen] != kind) begin
                shape_ok = 1'b0;
            end
            tokens_seen = tokens_seen + 3'd1;
        end
        put_token(kind, chr, start, len, 1'b0);
    endfunction

    // Error: spoil the shape and skip to the end of the formula
    function automatic void put_error(input int start, input int len);
        shape_ok  = 1'b0;
        lex_state = MODE_SKIP;
        put_token(KIND_ERR, 8'h00, start, len, 1'b0);
    endfunction

    // Final end token, then start the next formula afresh
    function automatic void close_formula();
        put_token(KIND_END, 8'h00, here_pos, 0, shape_ok && (tokens_seen >= PATTERN_MIN));
        lex_state   = MODE_IDLE;
        ident_len   = 8'd0;
        ident_start = 0;
        ident_digit = 1'b0;
        dots_seen   = 3'd0;
        byte_pos    = 0;
        tokens_seen = 3'd0;
        shape_ok    = 1'b1;
    endfunction

    // Lex a byte with no identifier or dot run open
    function automatic void lex_fresh(input logic [7:0] c);
        lex_state = MODE_IDLE;
        if (c == CH_NUL) begin
            close_formula();
        end else if (is_letter(c)) begin
            lex_state   = MODE_IDENT;
            ident_start = here_pos;
            ident_len   = 8'd1;
            ident_digit = 1'b0;
        end else if (c inside {CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_LPAR}) begin
            put_counted(KIND_SYM, c, here_pos, 1);
        end else if (c == CH_RPAR) begin
            put_counted(KIND_END, c, here_pos, 1);
        end else if (c == CH_DOT) begin
            lex_state   = MODE_DOTS;
            ident_start = here_pos;
            dots_seen   = 3'd1;
        end else if (!(c == CH_SPACE || c == CH_LF)) begin
            put_error(here_pos, 1);
        end
    endfunction

    // Work out the tokens of one accepted byte into step_tokens
    function automatic void lex_byte(input logic [7:0] c);
        step_tokens.delete();
        here_pos = byte_pos;
        if (byte_pos < POS_MAX) begin
            byte_pos = byte_pos + 1;
        end
        case (lex_state)
            MODE_IDENT: begin
                if (is_letter(c) || is_digit(c) || c == CH_UNDER) begin
                    if (ident_len != 8'hFF) begin
                        ident_len = ident_len + 8'd1;
                    end
                    if (is_digit(c)) begin
                        ident_digit = 1'b1;
                    end
                end else begin
                    put_counted(ident_digit ? KIND_CELL : KIND_FUNC, 8'h00,
                                ident_start, int'(ident_len));
                    lex_fresh(c);
                end
            end
            MODE_DOTS: begin
                if (c == CH_DOT) begin
                    if (dots_seen != 3'd7) begin
                        dots_seen = dots_seen + 3'd1;
                    end
                end else if (dots_seen == RANGE_DOTS) begin
                    put_counted(KIND_RANGE, 8'h00, ident_start, 3);
                    lex_fresh(c);
                end else begin
                    put_error(ident_start, int'(dots_seen));
                    if (c == CH_NUL) begin
                        close_formula();
                    end
                end
            end
            MODE_SKIP: begin
                if (c == CH_NUL) begin
                    close_formula();
                end
            end
            default: begin
                lex_fresh(c);
            end
        endcase
        if (step_tokens.size() > 0) begin
            step_tokens[$].last = 1'b1;
        end
    endfunction

    function automatic void queue_step();
        foreach (step_tokens[i]) begin
            token_queue.push_back(step_tokens[i]);
        end
    endfunction

    // ------------------------------------------------------------------
    // Formula generation
    // ------------------------------------------------------------------
    function automatic logic [7:0] any_letter();
        logic [7:0] base;
        base = $urandom_range(0, 1) ? 8'h41 : 8'h61;
        return base + 8'($urandom_range(0, 25));
    endfunction

    // Identifier; a cell reference always gets at least one digit
    function automatic void add_ident(input logic as_cell, input int tail);
        logic [7:0] c;
        logic       got_digit;
        got_digit = 1'b0;
        formula_text.push_back(any_letter());
        repeat ($urandom_range(0, tail)) begin
            case ($urandom_range(0, 3))
                0:       c = CH_UNDER;
                1:       c = as_cell ? 8'h30 + 8'($urandom_range(0, 9)) : CH_UNDER;
                default: c = any_letter();
            endcase
            if (is_digit(c)) begin
                got_digit = 1'b1;
            end
            formula_text.push_back(c);
        end
        if (as_cell && !got_digit) begin
            formula_text.push_back(8'h30 + 8'($urandom_range(0, 9)));
        end
    endfunction

    function automatic void add_blanks();
        repeat (($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0) begin
            formula_text.push_back($urandom_range(0, 1) ? CH_SPACE : CH_LF);
        end
    endfunction

    // function ( cell ... cell ), blanks sprinkled between
    function automatic void add_range_formula();
        add_ident(1'b0, 5);
        add_blanks();
        formula_text.push_back(CH_LPAR);
        add_blanks();
        add_ident(1'b1, 3);
        add_blanks();
        repeat (3) formula_text.push_back(CH_DOT);
        add_blanks();
        add_ident(1'b1, 3);
        add_blanks();
        formula_text.push_back(CH_RPAR);
    endfunction

    function automatic void make_formula(input int index);
        int         style;
        logic [7:0] c;
        formula_text.delete();
        if (index == LONG_IDENT_AT) begin
            // identifier well past the length saturation
            formula_text.push_back("Q");
            repeat (260) formula_text.push_back(any_letter());
            formula_text.push_back("7");
            formula_text.push_back(CH_PLUS);
        end else if (index == LONG_LINE_AT) begin
            // push the tokens beyond the last representable position
            repeat (258) formula_text.push_back(CH_SPACE);
            add_range_formula();
        end else begin
            style = $urandom_range(0, 99);
            if (style < 50) begin
                add_range_formula();
                if ($urandom_range(0, 3) == 0) begin
                    formula_text[$urandom_range(0, formula_text.size() - 1)] =
                        8'($urandom_range(1, 255));
                end
            end else if (style < 85) begin
                repeat ($urandom_range(1, 8)) begin
                    case ($urandom_range(0, 9))
                        0, 1: add_ident(1'b0, 4);
                        2, 3: add_ident(1'b1, 4);
                        4:    formula_text.push_back(sym_chars[$urandom_range(0, 4)]);
                        5:    formula_text.push_back(CH_RPAR);
                        6: begin
                            repeat (($urandom_range(0, 2) == 0) ? $urandom_range(1, 8) : 3)
                                formula_text.push_back(CH_DOT);
                        end
                        7: begin
                            formula_text.push_back(CH_SPACE);
                            add_blanks();
                        end
                        8: begin
                            do begin
                                c = 8'($urandom_range(1, 255));
                            end while (is_letter(c) || c inside {CH_PLUS, CH_MINUS,
                                       CH_STAR, CH_SLASH, CH_LPAR, CH_RPAR, CH_DOT,
                                       CH_SPACE, CH_LF});
                            formula_text.push_back(c);
                        end
                        default: formula_text.push_back(8'($urandom_range(8'h21, 8'h7E)));
                    endcase
                end
            end else begin
                repeat ($urandom_range(1, 10)) formula_text.push_back(8'($urandom_range(0, 255)));
            end
        end
        formula_text.push_back(CH_NUL);
    endfunction

    // ------------------------------------------------------------------
    // Byte sender
    // ------------------------------------------------------------------
    task automatic accept_byte(input logic [7:0] c);
        if (idling_on && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        do @(posedge aclk); while (!s_tready);
        lex_byte(c);
    endtask

    initial begin : stimulus
        int formula_no;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table
        foreach (directed_rows[i]) begin
            accept_byte(directed_rows[i].c);
            if (directed_rows[i].typed_n == 0) begin
                queue_step();
            end else begin
                token_queue.push_back(directed_rows[i].r0);
                if (directed_rows[i].typed_n == 2) begin
                    token_queue.push_back(directed_rows[i].r1);
                end
            end
        end

        // Random formulas
        formula_no = 0;
        while (sent_count < RANDOM_ITEMS) begin
            if (formula_no == 2) begin
                hold_off_req = 1'b1;
            end
            // pause until every token has been taken
            if (formula_no % 40 == 6) begin
                s_tvalid <= 1'b0;
                while (token_queue.size() != 0) @(posedge aclk);
                @(posedge aclk);
            end
            make_formula(formula_no);
            foreach (formula_text[k]) begin
                accept_byte(formula_text[k]);
                queue_step();
                sent_count++;
                if (sent_count > QUIET_AFTER) begin
                    idling_on = 1'b0;
                end
            end
            formula_no++;
        end
        s_tvalid <= 1'b0;

        // Drain, then allow for stray tokens
        while (token_queue.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (miss_count == 0) begin
            $display("formula_token_lexer regression: pass");
        end else begin
            $display("formula_token_lexer regression: fail");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Token receiver: random back-pressure plus one long hold-off
    // ------------------------------------------------------------------
    initial begin : receiver
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
            end else if (idling_on && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat (idling_on ? $urandom_range(1, 30) : 1) @(posedge aclk);
            end
        end
    end

    // ------------------------------------------------------------------
    // Token check
    // ------------------------------------------------------------------
    function automatic void note_miss(input string what, input result_t want,
                                      input result_t got);
        miss_count++;
        if (miss_count <= SHOWN_MISSES) begin
            $display("%s: want kind=%0d chr=%h start=%0d len=%0d valid=%b last=%b",
                     what, want.kind, want.chr, want.start, want.length, want.valid,
                     want.last);
            $display("  got kind=%0d chr=%h start=%0d len=%0d valid=%b last=%b",
                     got.kind, got.chr, got.start, got.length, got.valid, got.last);
        end
    endfunction

    always @(posedge aclk) begin : token_check
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.kind   = token_kind_t'(m_tuser);
            got.chr    = m_tdata[7:0];
            got.start  = m_tdata[15:8];
            got.length = m_tdata[23:16];
            got.valid  = m_tdata[24];
            got.last   = m_tlast;
            if (token_queue.size() == 0) begin
                note_miss("unexpected token", NO_TOKEN, got);
            end else begin
                want = token_queue.pop_front();
                if (got.kind !== want.kind || got.chr !== want.chr
                        || got.start !== want.start || got.length !== want.length
                        || got.valid !== want.valid || got.last !== want.last) begin
                    note_miss("token mismatch", want, got);
                end
            end
        end
    end

    // Stop a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("formula_token_lexer regression: fail");
            $finish;
        end
    end

endmodule
